[hw/rtl/cvw_pkg.sv]
// Shared types, constants and coefficient selection for conv2d_valid_window.
// No dependencies; cvw_front, cvw_back, the top level and the testbench import this package.
package cvw_pkg;

  // Default line length of the line store
  localparam int MAX_WIDTH_DEF = 1024;

  // Depth of the queue between front and back, and of the result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH   = 8;
  localparam int QCW         = $clog2(QUEUE_DEPTH + 1);
  localparam int OCW         = $clog2(OUT_DEPTH + 1);

  // Configuration register indexes
  localparam logic [2:0] REG_KROW0    = 3'd0;
  localparam logic [2:0] REG_KROW1    = 3'd1;
  localparam logic [2:0] REG_KROW2    = 3'd2;
  localparam logic [2:0] REG_KHEIGHT  = 3'd3;
  localparam logic [2:0] REG_KWIDTH   = 3'd4;
  localparam logic [2:0] REG_IWIDTH   = 3'd5;
  localparam logic [2:0] REG_IHEIGHT  = 3'd6;

  // Configuration as seen by front and back
  typedef struct packed {
    logic [23:0] krow0;
    logic [23:0] krow1;
    logic [23:0] krow2;
    logic [1:0]  kh;
    logic [1:0]  kw;
    logic [10:0] iw;
    logic [15:0] ih;
  } cfg_t;

  // One column of three pixels plus what the front decided about it
  typedef struct packed {
    logic [7:0]  top;
    logic [7:0]  mid;
    logic [7:0]  bot;
    logic        has_res;
    logic [15:0] row;
    logic [9:0]  col;
    logic        last;
  } item_t;

  // One result word
  typedef struct packed {
    logic signed [19:0] sum;
    logic [15:0]        row;
    logic [9:0]         col;
    logic               last;
  } res_t;

  // Coefficient that meets window cell (a, b); zero outside the kernel in use
  function automatic logic signed [7:0] coef_at(cfg_t cfg, int a, int b);
    logic [1:0]  kh;
    logic [1:0]  kw;
    logic [23:0] rowp;
    int          i;
    int          j;
    kh = (cfg.kh == 2'd0) ? 2'd1 : cfg.kh;
    kw = (cfg.kw == 2'd0) ? 2'd1 : cfg.kw;
    i  = a - (3 - int'(kh));
    j  = b - (3 - int'(kw));
    case (i)
      0:       rowp = cfg.krow0;
      1:       rowp = cfg.krow1;
      2:       rowp = cfg.krow2;
      default: rowp = '0;
    endcase
    if (i < 0 || j < 0) begin
      return 8'sd0;
    end
    return $signed(rowp[8*j +: 8]);
  endfunction

endpackage

[hw/rtl/cvw_ram.sv]
// Generic single-write, single-read RAM with registered read (read-first).
// No dependencies.
module cvw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/cvw_fifo.sv]
// Small register queue with fall-through head and an occupancy count.
// No dependencies; callers guarantee no push when full and no pop when empty.
module cvw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty,
  output logic [CW-1:0]    count
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = mem_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign count = count_r;

endmodule

[hw/rtl/cvw_front.sv]
// Front end: accepts pixels, tracks row and column, runs the line store and
// hands one pixel column per word to the queue. Uses cvw_pkg and cvw_ram.
module cvw_front
  import cvw_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int CW        = $clog2(MAX_WIDTH),
  parameter int WW        = $clog2(MAX_WIDTH + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  cfg_t           cfg,
  input  logic           push,
  input  logic [7:0]     pixel,
  output logic           full,
  input  logic [QCW-1:0] q_count,
  output logic           q_push,
  output item_t          q_item
);

  logic [15:0]   row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic          acc;
  logic [WW-1:0] w_eff;
  logic [15:0]   h_eff;
  logic [1:0]    kh_eff, kw_eff;
  logic [15:0]   r_use;
  logic [CW-1:0] c_use;
  logic [31:0]   col_diff;
  logic          has_res;
  logic          last;

  logic          f1_valid_r;
  logic [CW-1:0] f1_col_r;
  logic [7:0]    f1_px_r;
  logic          f1_has_r;
  logic [15:0]   f1_row_out_r;
  logic [9:0]    f1_col_out_r;
  logic          f1_last_r;
  logic          f1_fwd_r;
  logic [15:0]   f1_fwd_word_r;
  logic [15:0]   ram_rdata;
  logic [15:0]   old_word;
  logic [15:0]   new_word;

  // Hold off input while the queue could overflow
  assign full = ((QCW + 1)'(q_count) + (QCW + 1)'(f1_valid_r)) >= (QCW + 1)'(QUEUE_DEPTH);
  assign acc  = push & ~full;

  // Effective sizes
  always_comb begin
    if (cfg.iw == 11'd0) begin
      w_eff = WW'(1);
    end else if (int'(cfg.iw) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg.iw);
    end
    h_eff  = (cfg.ih == 16'd0) ? 16'd1 : cfg.ih;
    kh_eff = (cfg.kh == 2'd0) ? 2'd1 : cfg.kh;
    kw_eff = (cfg.kw == 2'd0) ? 2'd1 : cfg.kw;
  end

  // Classify the pixel and step the counters
  always_comb begin
    r_use = row_r;
    c_use = col_r;
    if (row_r >= h_eff || 32'(col_r) >= 32'(w_eff)) begin
      r_use = '0;
      c_use = '0;
    end
    has_res  = (17'(r_use) + 17'd1 >= 17'(kh_eff)) &&
               (32'(c_use) + 32'd1 >= 32'(kw_eff));
    col_diff = 32'(c_use) + 32'd1 - 32'(kw_eff);
    last     = (r_use == h_eff - 16'd1) && (32'(c_use) == 32'(w_eff) - 32'd1);
    if (32'(c_use) + 32'd1 >= 32'(w_eff)) begin
      col_nxt = '0;
      row_nxt = (17'(r_use) + 17'd1 >= 17'(h_eff)) ? 16'd0 : r_use + 16'd1;
    end else begin
      col_nxt = c_use + 1'b1;
      row_nxt = r_use;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      col_r      <= '0;
      f1_valid_r <= 1'b0;
    end else begin
      f1_valid_r <= acc;
      if (acc) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
    end
  end

  // Capture the pixel and its outcome; forward a same-column write
  always_ff @(posedge clk) begin
    if (acc) begin
      f1_col_r      <= c_use;
      f1_px_r       <= pixel;
      f1_has_r      <= has_res;
      f1_row_out_r  <= r_use + 16'd1 - 16'(kh_eff);
      f1_col_out_r  <= col_diff[9:0];
      f1_last_r     <= last;
      f1_fwd_r      <= f1_valid_r && (f1_col_r == c_use);
      f1_fwd_word_r <= new_word;
    end
  end

  // Line store word: upper byte is the newer line, lower byte the older
  cvw_ram #(
    .WIDTH (16),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (f1_valid_r),
    .waddr (f1_col_r),
    .wdata (new_word),
    .raddr (c_use),
    .rdata (ram_rdata)
  );

  assign old_word = f1_fwd_r ? f1_fwd_word_r : ram_rdata;
  assign new_word = {f1_px_r, old_word[15:8]};

  // Hand the column to the back end
  assign q_push         = f1_valid_r;
  assign q_item.top     = old_word[7:0];
  assign q_item.mid     = old_word[15:8];
  assign q_item.bot     = f1_px_r;
  assign q_item.has_res = f1_has_r;
  assign q_item.row     = f1_row_out_r;
  assign q_item.col     = f1_col_out_r;
  assign q_item.last    = f1_last_r;

endmodule

[hw/rtl/cvw_back.sv]
// Back end: shifts columns into the 3x3 window, multiplies and sums, and
// queues results. Uses cvw_pkg and cvw_fifo.
module cvw_back
  import cvw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               q_empty,
  input  item_t              q_item,
  output logic               q_pop,
  input  logic               pop,
  output logic               empty,
  output logic signed [19:0] out_conv_sum,
  output logic [15:0]        out_row,
  output logic [9:0]         out_col,
  output logic               out_frame_last
);

  logic [7:0]         win_r [3][3];
  logic               b1_v_r, b2_v_r, b3_v_r;
  logic               b1_has_r, b2_has_r, b3_has_r;
  logic [15:0]        b1_row_r, b2_row_r, b3_row_r;
  logic [9:0]         b1_col_r, b2_col_r, b3_col_r;
  logic               b1_last_r, b2_last_r, b3_last_r;
  logic signed [7:0]  coef [3][3];
  logic [1:0]         kh_eff;
  logic [1:0]         kw_eff;
  logic               cell_on [3][3];
  logic signed [16:0] prod_r [3][3];
  logic signed [18:0] rsum_r [3];
  logic signed [20:0] total;
  logic [OCW:0]       slots;
  logic [OCW-1:0]     oq_count;
  logic               oq_push;
  res_t               oq_wdata;
  res_t               oq_rdata;

  // Pop only when every word in flight has a place in the result queue
  assign slots = (OCW + 1)'(oq_count) + (OCW + 1)'(b1_v_r) + (OCW + 1)'(b2_v_r) +
                 (OCW + 1)'(b3_v_r) + (OCW + 1)'(1);
  assign q_pop = ~q_empty && (slots <= (OCW + 1)'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
      b3_v_r <= 1'b0;
    end else begin
      b1_v_r <= q_pop;
      b2_v_r <= b1_v_r;
      b3_v_r <= b2_v_r;
    end
  end

  // Shift the window left and take the new column on the right
  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int a = 0; a < 3; a++) begin
        win_r[a][0] <= win_r[a][1];
        win_r[a][1] <= win_r[a][2];
      end
      win_r[0][2] <= q_item.top;
      win_r[1][2] <= q_item.mid;
      win_r[2][2] <= q_item.bot;
      b1_has_r    <= q_item.has_res;
      b1_row_r    <= q_item.row;
      b1_col_r    <= q_item.col;
      b1_last_r   <= q_item.last;
    end
  end

  // Coefficients aligned to the bottom-right of the window, and the cells in use
  always_comb begin
    kh_eff = (cfg.kh == 2'd0) ? 2'd1 : cfg.kh;
    kw_eff = (cfg.kw == 2'd0) ? 2'd1 : cfg.kw;
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        coef[a][b]    = coef_at(cfg, a, b);
        cell_on[a][b] = (a >= 3 - int'(kh_eff)) && (b >= 3 - int'(kw_eff));
      end
    end
  end

  // Multiply; drop cells outside the kernel so stale pixels never reach the sum
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        prod_r[a][b] <= cell_on[a][b] ? coef[a][b] * $signed({1'b0, win_r[a][b]})
                                      : 17'sd0;
      end
    end
    b2_has_r  <= b1_has_r;
    b2_row_r  <= b1_row_r;
    b2_col_r  <= b1_col_r;
    b2_last_r <= b1_last_r;
  end

  // Sum each row
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      rsum_r[a] <= 19'(prod_r[a][0]) + 19'(prod_r[a][1]) + 19'(prod_r[a][2]);
    end
    b3_has_r  <= b2_has_r;
    b3_row_r  <= b2_row_r;
    b3_col_r  <= b2_col_r;
    b3_last_r <= b2_last_r;
  end

  // Final sum into the result queue
  assign total         = 21'(rsum_r[0]) + 21'(rsum_r[1]) + 21'(rsum_r[2]);
  assign oq_push       = b3_v_r & b3_has_r;
  assign oq_wdata.sum  = total[19:0];
  assign oq_wdata.row  = b3_row_r;
  assign oq_wdata.col  = b3_col_r;
  assign oq_wdata.last = b3_last_r;

  cvw_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .wdata (oq_wdata),
    .pop   (pop & ~empty),
    .rdata (oq_rdata),
    .empty (empty),
    .count (oq_count)
  );

  assign out_conv_sum   = oq_rdata.sum;
  assign out_row        = oq_rdata.row;
  assign out_col        = oq_rdata.col;
  assign out_frame_last = oq_rdata.last;

endmodule

[hw/rtl/conv2d_valid_window.sv]
// Top level of the streaming 3x3 valid-window convolution: register port,
// front end, column queue and back end. Uses cvw_pkg, cvw_front, cvw_fifo, cvw_back.
//
// Channel   Ports                                   Moves
// input     push, full, in_pixel                    one pixel word per accept
// result    pop, empty, out_conv_sum, out_row,      one result word per accept
//           out_col, out_frame_last
// config    psel, penable, pwrite, paddr, pwdata,   one register per 32-bit write
//           prdata, pready
//
// One pixel is taken every cycle while full is low; the line store is read and
// written once per pixel, which sets that rate. A result passes through the front
// register, column queue, window, product and row-sum registers and result queue.
// Reset (rst_n low, synchronous) clears counters, queues and registers to their
// defaults; line store and window contents are undefined until written.
// Input stalls only when the column queue fills, which happens only when results
// are not being popped.
module conv2d_valid_window
  import cvw_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         in_pixel,
  output logic               empty,
  input  logic               pop,
  output logic signed [19:0] out_conv_sum,
  output logic [15:0]        out_row,
  output logic [9:0]         out_col,
  output logic               out_frame_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t           cfg_r;
  logic           cfg_we;
  logic [2:0]     cfg_idx;
  logic           q_push;
  logic           q_pop;
  logic           q_empty;
  logic [QCW-1:0] q_count;
  item_t          q_wdata;
  item_t          q_rdata;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[4:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.krow0 <= '0;
      cfg_r.krow1 <= '0;
      cfg_r.krow2 <= '0;
      cfg_r.kh    <= 2'd3;
      cfg_r.kw    <= 2'd3;
      cfg_r.iw    <= 11'd1024;
      cfg_r.ih    <= 16'd1024;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_KROW0:   cfg_r.krow0 <= pwdata[23:0];
        REG_KROW1:   cfg_r.krow1 <= pwdata[23:0];
        REG_KROW2:   cfg_r.krow2 <= pwdata[23:0];
        REG_KHEIGHT: cfg_r.kh    <= pwdata[1:0];
        REG_KWIDTH:  cfg_r.kw    <= pwdata[1:0];
        REG_IWIDTH:  cfg_r.iw    <= pwdata[10:0];
        REG_IHEIGHT: cfg_r.ih    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (cfg_idx)
      REG_KROW0:   prdata = 32'(cfg_r.krow0);
      REG_KROW1:   prdata = 32'(cfg_r.krow1);
      REG_KROW2:   prdata = 32'(cfg_r.krow2);
      REG_KHEIGHT: prdata = 32'(cfg_r.kh);
      REG_KWIDTH:  prdata = 32'(cfg_r.kw);
      REG_IWIDTH:  prdata = 32'(cfg_r.iw);
      REG_IHEIGHT: prdata = 32'(cfg_r.ih);
      default:     prdata = '0;
    endcase
  end

  cvw_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .push    (push),
    .pixel   (in_pixel),
    .full    (full),
    .q_count (q_count),
    .q_push  (q_push),
    .q_item  (q_wdata)
  );

  // Column queue between front and back
  cvw_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_col_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .count (q_count)
  );

  cvw_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_empty        (q_empty),
    .q_item         (q_rdata),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .out_conv_sum   (out_conv_sum),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_frame_last (out_frame_last)
  );

endmodule

[dv/tb_conv2d_valid_window.sv]
`timescale 1ns / 100ps
// Self-checking testbench for conv2d_valid_window: random raster frames and
// kernels are pushed in, and each result word is checked against a predictor.
// Depends on cvw_pkg and the conv2d_valid_window RTL only.
module tb_conv2d_valid_window;
  import cvw_pkg::*;

  localparam int LINE_MAX     = MAX_WIDTH_DEF;
  localparam int RANDOM_ITEMS = 1030;
  localparam int DRAIN_CYCLES = 16;
  localparam int PRINT_CAP    = 40;

  logic               clk      = 1'b0;
  logic               rst_n    = 1'b0;
  logic               push     = 1'b0;
  logic               full;
  logic [7:0]         in_pixel = '0;
  logic               empty;
  logic               pop      = 1'b0;
  logic signed [19:0] out_conv_sum;
  logic [15:0]        out_row;
  logic [9:0]         out_col;
  logic               out_frame_last;
  logic               psel     = 1'b0;
  logic               penable  = 1'b0;
  logic               pwrite   = 1'b0;
  logic [4:0]         paddr    = '0;
  logic [31:0]        pwdata   = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Shadow of the register file
  logic [23:0] k_row [3];
  logic [1:0]  k_h;
  logic [1:0]  k_w;
  logic [10:0] img_w;
  logic [15:0] img_h;

  // Shadow of the line stores, window and raster position
  logic [7:0]  line_mem [2][LINE_MAX];
  logic [7:0]  win [3][3];
  int unsigned row_ctr;
  int unsigned col_ctr;

  logic [7:0]  pixel_feed[$];
  res_t        expected_results[$];
  int          errors        = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  conv2d_valid_window dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_pixel       (in_pixel),
    .empty          (empty),
    .pop            (pop),
    .out_conv_sum   (out_conv_sum),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_frame_last (out_frame_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (errors < PRINT_CAP) begin
      $display("%0t: mismatch: %s", $time, msg);
    end
    errors++;
  endtask

  // Advance the window by one pixel and queue the result word it produces, if any
  function automatic void convolve_pixel(input logic [7:0] px);
    int unsigned      w;
    int unsigned      h;
    int unsigned      kh;
    int unsigned      kw;
    int unsigned      r;
    int unsigned      c;
    int               acc;
    logic signed [7:0] cf;
    res_t             want;
    w  = (img_w == 0) ? 1 : ((img_w > LINE_MAX) ? LINE_MAX : img_w);
    h  = (img_h == 0) ? 1 : img_h;
    kh = (k_h == 0) ? 1 : k_h;
    kw = (k_w == 0) ? 1 : k_w;
    // restart the frame when a size change left the position outside it
    if (row_ctr >= h || col_ctr >= w) begin
      row_ctr = 0;
      col_ctr = 0;
    end
    r = row_ctr;
    c = col_ctr;
    for (int a = 0; a < 3; a++) begin
      win[a][0] = win[a][1];
      win[a][1] = win[a][2];
    end
    win[0][2]   = line_mem[0][c];
    win[1][2]   = line_mem[1][c];
    win[2][2]   = px;
    line_mem[0][c] = line_mem[1][c];
    line_mem[1][c] = px;
    // a result only where the whole kernel lies inside the image
    if (r + 1 >= kh && c + 1 >= kw) begin
      acc = 0;
      for (int i = 0; i < kh; i++) begin
        for (int j = 0; j < kw; j++) begin
          cf  = k_row[i][8*j +: 8];
          acc += int'(cf) * int'(win[3 - kh + i][3 - kw + j]);
        end
      end
      want.sum  = acc[19:0];
      want.row  = 16'(r + 1 - kh);
      want.col  = 10'(c + 1 - kw);
      want.last = (r == h - 1) && (c == w - 1);
      expected_results.push_back(want);
    end
    if (c + 1 >= w) begin
      col_ctr = 0;
      row_ctr = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_ctr = c + 1;
    end
  endfunction

  // Pixel driver: keep offering the head word, with random idles, until it is taken
  always @(posedge clk) begin : pixel_driver
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        convolve_pixel(pixel_feed.pop_front());
      end
      if (pixel_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        push     <= 1'b1;
        in_pixel <= pixel_feed[0];
      end else begin
        push     <= 1'b0;
        in_pixel <= 8'($urandom);
      end
    end
  end

  // Result monitor: compare each popped word with the oldest expectation
  always @(posedge clk) begin : result_monitor
    res_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result at row %0d col %0d",
                                    out_row, out_col));
        end else begin
          want = expected_results.pop_front();
          if (out_conv_sum !== want.sum) begin
            report_mismatch($sformatf("conv_sum got %0d, expected %0d (row %0d col %0d)",
                                      out_conv_sum, want.sum, want.row, want.col));
          end
          if (out_row !== want.row) begin
            report_mismatch($sformatf("out_row got %0d, expected %0d", out_row, want.row));
          end
          if (out_col !== want.col) begin
            report_mismatch($sformatf("out_col got %0d, expected %0d", out_col, want.col));
          end
          if (out_frame_last !== want.last) begin
            report_mismatch($sformatf("frame_last got %b, expected %b (row %0d col %0d)",
                                      out_frame_last, want.last, want.row, want.col));
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Register write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_KROW0:   k_row[0] = value[23:0];
      REG_KROW1:   k_row[1] = value[23:0];
      REG_KROW2:   k_row[2] = value[23:0];
      REG_KHEIGHT: k_h      = value[1:0];
      REG_KWIDTH:  k_w      = value[1:0];
      REG_IWIDTH:  img_w    = value[10:0];
      REG_IHEIGHT: img_h    = value[15:0];
      default: ;
    endcase
  endtask

  task automatic set_image(input int w, input int h, input int kh, input int kw);
    write_reg(REG_KHEIGHT, kh);
    write_reg(REG_KWIDTH, kw);
    write_reg(REG_IWIDTH, w);
    write_reg(REG_IHEIGHT, h);
  endtask

  // Coefficient row weighted towards the signed extremes, zero and minus one
  function automatic logic [23:0] rand_coeff_row();
    logic [23:0] row;
    for (int j = 0; j < 3; j++) begin
      case ($urandom_range(5))
        0:       row[8*j +: 8] = 8'h80;
        1:       row[8*j +: 8] = 8'h7f;
        2:       row[8*j +: 8] = 8'h00;
        3:       row[8*j +: 8] = 8'hff;
        default: row[8*j +: 8] = 8'($urandom);
      endcase
    end
    return row;
  endfunction

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic int rand_kernel_dim();
    return ($urandom_range(11) == 0) ? 0 : $urandom_range(3, 1);
  endfunction

  task automatic feed_random(input int n);
    repeat (n) pixel_feed.push_back(rand_pixel());
  endtask

  // Hold until every pixel is taken and every result word has come back
  task automatic wait_drained();
    while (pixel_feed.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_kernel();
    write_reg(REG_KROW0, 32'(rand_coeff_row()));
    write_reg(REG_KROW1, 32'(rand_coeff_row()));
    write_reg(REG_KROW2, 32'(rand_coeff_row()));
  endtask

  // Whole frames at one shape; the counters end at the frame start again
  task automatic run_frames(input int w, input int h, input int nframes, inout int fed);
    random_kernel();
    set_image(w, h, rand_kernel_dim(), rand_kernel_dim());
    feed_random(w * h * nframes);
    fed += w * h * nframes;
    wait_drained();
  endtask

  // Stop part way into a frame, then shrink the image so the next pixel restarts it
  task automatic run_cut_frame(input logic wide, inout int fed);
    int w;
    int h;
    int npix;
    random_kernel();
    if (wide) begin
      set_image(2047, 65535, 1, $urandom_range(3, 1));
      npix = $urandom_range(60, 30);
    end else begin
      w    = $urandom_range(10, 3);
      h    = $urandom_range(8, 4);
      set_image(w, h, rand_kernel_dim(), rand_kernel_dim());
      npix = w * $urandom_range(h - 1, 2) + $urandom_range(w - 1, 1);
    end
    feed_random(npix);
    fed += npix;
    wait_drained();
    if (row_ctr > 0) begin
      run_frames($urandom_range(12, 1), $urandom_range(row_ctr, 1), 1, fed);
    end else begin
      run_frames($urandom_range((col_ctr < 12) ? col_ctr : 12, 1),
                 $urandom_range(6, 1), 1, fed);
    end
  endtask

  initial begin : stimulus
    int fed;
    int phase;
    k_row    = '{default: '0};
    k_h      = 2'd3;
    k_w      = 2'd3;
    img_w    = 11'd1024;
    img_h    = 16'd1024;
    win      = '{default: '{default: '0}};
    line_mem = '{default: '{default: '0}};
    row_ctr  = 0;
    col_ctr  = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 36;
    recv_idle_pct = 65;

    // most negative sum: all coefficients -128 over a white 3x3 image
    write_reg(REG_KROW0, 32'h0080_8080);
    write_reg(REG_KROW1, 32'h0080_8080);
    write_reg(REG_KROW2, 32'h0080_8080);
    set_image(3, 3, 3, 3);
    repeat (9) pixel_feed.push_back(8'hff);
    wait_drained();

    // most positive sum: all coefficients +127
    write_reg(REG_KROW0, 32'h007f_7f7f);
    write_reg(REG_KROW1, 32'h007f_7f7f);
    write_reg(REG_KROW2, 32'h007f_7f7f);
    repeat (9) pixel_feed.push_back(8'hff);
    wait_drained();

    // zero sizes and zero kernel dimensions act as one: 1x1 frames
    write_reg(REG_KROW0, 32'(rand_coeff_row()));
    set_image(0, 0, 0, 0);
    pixel_feed.push_back(8'h00);
    pixel_feed.push_back(8'hff);
    wait_drained();

    // image smaller than the kernel gives nothing
    set_image(2, 2, 3, 3);
    feed_random(4);
    wait_drained();

    // random phases; idling pattern follows progress through the items
    fed   = 0;
    phase = 0;
    while (fed < RANDOM_ITEMS) begin
      if (fed >= 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (fed >= RANDOM_ITEMS / 3) begin
        send_idle_pct = 65;
        recv_idle_pct = 36;
      end else begin
        send_idle_pct = 36;
        recv_idle_pct = 65;
      end
      if (phase % 9 == 4) begin
        run_cut_frame(1'b1, fed);
      end else if (phase % 5 == 2) begin
        run_cut_frame(1'b0, fed);
      end else if ($urandom_range(7) == 0) begin
        run_frames($urandom_range(40, 13), $urandom_range(4, 1), 1, fed);
      end else begin
        run_frames($urandom_range(12, 1), $urandom_range(8, 1), $urandom_range(3, 1), fed);
      end
      phase++;
    end

    wait_drained();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin : watchdog
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
